@@ sv/ppu_pkg.sv @@
// ----------------------------------------------------------------------------
// ppu_pkg: shared types and constants of the particle pool update block
// Holds the pool size, register indexes, state codes and the command and
// status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package ppu_pkg;

	localparam int Particles = 32;
	localparam int IdxW      = $clog2(Particles);
	localparam int CntW      = $clog2(Particles + 1);

	localparam logic [2:0] REG_RATE_LIFE = 3'd0;
	localparam logic [2:0] REG_SPEED     = 3'd1;
	localparam logic [2:0] REG_COLOUR    = 3'd2;
	localparam logic [2:0] REG_SIZE      = 3'd3;
	localparam logic [2:0] REG_PLACE     = 3'd4;
	localparam logic [2:0] REG_VEL       = 3'd5;
	localparam logic [2:0] REG_ACCEL     = 3'd6;
	localparam logic [2:0] REG_COUNT     = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DT,
		ST_ACC,
		ST_READ,
		ST_AGE,
		ST_VEL,
		ST_POS,
		ST_DIV,
		ST_LERP,
		ST_EMIT
	} ppu_state_t;

	typedef struct packed {
		logic       take_tick;
		logic       calc_dt;
		logic       calc_acc;
		logic       read_slot;
		logic       calc_age;
		logic       calc_vel;
		logic       calc_pos;
		logic       div_start;
		logic       calc_lerp;
		logic       load_out;
		logic [IdxW-1:0] slot;
		logic       last;
	} ppu_cmd_t;

	typedef struct packed {
		logic div_done;
		logic div_skip;
	} ppu_stat_t;

	// sign-extend one Q8.8 axis of a packed triple into Q16.16
	function automatic logic signed [31:0] half_q16(input logic [47:0] p, input logic [1:0] ax);
		logic [15:0] h;
		h = (ax == 2'd0) ? p[47:32] : ((ax == 2'd1) ? p[31:16] : p[15:0]);
		return {{8{h[15]}}, h, 8'h00};
	endfunction

	// floor(a*b/65536) on a signed a, unsigned b; 32x33 product
	function automatic logic signed [63:0] mulq(input logic signed [31:0] a,
		input logic [31:0] b);
		logic signed [64:0] p;
		p = 65'(a) * $signed({1'b0, b});
		return p[64:16] > 0 ? 64'(p >>> 16) : 64'(p >>> 16);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// floor(s + (e-s)*r/65536), r in 0..65536
	function automatic logic [15:0] lerp16(input logic [15:0] s, input logic [15:0] e,
		input logic [16:0] r);
		logic [33:0] p;
		if (e >= s) begin
			p = 34'(e - s) * 34'(r);
			return s + p[31:16];
		end
		p = 34'(s - e) * 34'(r) + 34'd65535;
		return s - p[31:16];
	endfunction

endpackage

@@ sv/particle_pool_update.sv @@
// ----------------------------------------------------------------------------
// particle_pool_update: one time tick advances a pool of particles
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: tick_delta with in_valid / in_stall. A tick transfers
//   when in_valid is high and in_stall low; in_stall stays high until the
//   last result of the tick has been loaded into the output register.
//   Output channel: one transfer per active particle, in slot order, with
//   out_valid / out_stall; final_slot marks the last of the tick.
//   Configuration: cfg_valid / cfg_ready, cfg_index, cfg_data; cfg_ready is
//   always high, write only while no tick is in flight.
//   Sequence: a tick runs its setup, then walks each active particle in
//   turn; the age ratio comes from a 48-step shift-subtract divider
//   (skipped when the particle has reached its lifetime).
//   Reset: registers return to their defaults, every particle is dead with
//   zero position and velocity, the spawn accumulator is cleared.
//   Stall: a stalled result holds in the output register; the walk waits.
// ----------------------------------------------------------------------------
module particle_pool_update import ppu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        tick_delta,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         slot,
	output logic signed [31:0] place_x,
	output logic signed [31:0] place_y,
	output logic signed [31:0] place_z,
	output logic [31:0]        tint,
	output logic [15:0]        extent,
	output logic [31:0]        age_now,
	output logic               final_slot,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	ppu_cmd_t   cmd;
	ppu_stat_t  stat;
	logic [6:0] active_count;

	assign cfg_ready = 1'b1;

	ppu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.active_count (active_count),
		.stat         (stat),
		.cmd          (cmd)
	);

	ppu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.tick_delta   (tick_delta),
		.cmd          (cmd),
		.stat         (stat),
		.active_count (active_count),
		.slot         (slot),
		.place_x      (place_x),
		.place_y      (place_y),
		.place_z      (place_z),
		.tint         (tint),
		.extent       (extent),
		.age_now      (age_now),
		.final_slot   (final_slot)
	);

endmodule

@@ sv/ppu_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppu_ctrl: sequencer of the particle pool update
// Walks the tick setup, then each active particle through its steps.
// ----------------------------------------------------------------------------
module ppu_ctrl import ppu_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            out_stall,
	output logic            out_valid,
	input  logic [6:0]      active_count,
	input  ppu_stat_t       stat,
	output ppu_cmd_t        cmd
);

	ppu_state_t state_q, state_d;
	logic [IdxW-1:0] slot_q;
	logic [CntW-1:0] n_q;
	logic            ovalid_q;
	logic            last;

	assign last = (CntW'(slot_q) + 1'b1) == n_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DT;
			ST_DT:   state_d = ST_ACC;
			ST_ACC:  state_d = (n_q == '0) ? ST_IDLE : ST_READ;
			ST_READ: state_d = ST_AGE;
			ST_AGE:  state_d = ST_VEL;
			ST_VEL:  state_d = ST_POS;
			ST_POS:  state_d = ST_DIV;
			ST_DIV:  if (stat.div_done || stat.div_skip) state_d = ST_LERP;
			ST_LERP: state_d = ST_EMIT;
			ST_EMIT: if (!ovalid_q || !out_stall) state_d = last ? ST_IDLE : ST_READ;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.slot = slot_q;
		cmd.last = last;
		unique case (state_q)
			ST_IDLE: cmd.take_tick = in_valid;
			ST_DT:   cmd.calc_dt = 1'b1;
			ST_ACC:  cmd.calc_acc = 1'b1;
			ST_READ: cmd.read_slot = 1'b1;
			ST_AGE:  cmd.calc_age = 1'b1;
			ST_VEL:  cmd.calc_vel = 1'b1;
			ST_POS:  begin
				cmd.calc_pos = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_DIV:  ;
			ST_LERP: cmd.calc_lerp = 1'b1;
			ST_EMIT: cmd.load_out = !ovalid_q || !out_stall;
			default: ;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			slot_q   <= '0;
			n_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.take_tick) begin
				slot_q <= '0;
				n_q <= (active_count > 7'(Particles)) ? CntW'(Particles) : CntW'(active_count);
			end
			if (cmd.load_out) begin
				ovalid_q <= 1'b1;
				if (!last) slot_q <= slot_q + 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && out_stall |=> ovalid_q) else $error("result dropped under stall");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_tick |=> state_q == ST_DT) else $error("tick not started");
	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE && state_q != ST_DT |-> CntW'(slot_q) < n_q || n_q == '0)
		else $error("slot beyond count");

endmodule

@@ sv/ppu_div.sv @@
// ----------------------------------------------------------------------------
// ppu_div: restoring divider for the age ratio
// Forms (age<<16)/life one quotient bit a cycle, 48 bits in all; the low 17
// quotient bits are kept.
// ----------------------------------------------------------------------------
module ppu_div import ppu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] age,
	input  logic [31:0] life,
	output logic        done,
	output logic [16:0] quot
);

	logic [47:0] num_q;
	logic [32:0] rem_q;
	logic [16:0] quot_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], num_q[47]} - {1'b0, life};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd48;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {age, 16'h0000};
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[46:0], 1'b0};
			if (!trial[32]) begin
				rem_q  <= trial;
				quot_q <= {quot_q[15:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[31:0], num_q[47]};
				quot_q <= {quot_q[15:0], 1'b0};
			end
		end
	end

	assign done = busy_q && cnt_q == 6'd1 ? 1'b0 : (!busy_q);
	assign quot = quot_q;

endmodule

@@ sv/ppu_dp.sv @@
// ----------------------------------------------------------------------------
// ppu_dp: datapath of the particle pool update
// Holds configuration, particle stores and the per-particle arithmetic.
// ----------------------------------------------------------------------------
module ppu_dp import ppu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	input  logic [31:0]         tick_delta,
	input  ppu_cmd_t            cmd,
	output ppu_stat_t           stat,
	output logic [6:0]          active_count,
	output logic [5:0]          slot,
	output logic signed [31:0]  place_x,
	output logic signed [31:0]  place_y,
	output logic signed [31:0]  place_z,
	output logic [31:0]         tint,
	output logic [15:0]         extent,
	output logic [31:0]         age_now,
	output logic                final_slot
);

	logic [63:0] rate_life_q, colour_q;
	logic [31:0] speed_q, size_q;
	logic [47:0] place0_q, vel0_q, accel_q;
	logic [6:0]  count_q;

	logic [Particles-1:0] born_q;
	logic [31:0] ages_q [Particles];
	logic signed [31:0] pos_q [Particles][3];
	logic signed [31:0] vel_q [Particles][3];
	logic [31:0] accum_q;

	logic [31:0] tick_q, dt_q, budget_q, age_q;
	logic signed [31:0] p_q [3];
	logic signed [31:0] v_q [3];
	logic [16:0] ratio_q;
	logic [31:0] tint_q;
	logic [15:0] ext_q;
	logic [31:0] life;

	logic        div_done;
	logic [16:0] quot;

	assign life = rate_life_q[31:0];
	assign active_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_life_q <= 64'd4295032832;
			speed_q     <= 32'd65536;
			colour_q    <= 64'hffffffff00000000;
			size_q      <= 32'h01000100;
			place0_q    <= '0;
			vel0_q      <= '0;
			accel_q     <= '0;
			count_q     <= 7'd32;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RATE_LIFE: rate_life_q <= cfg_data;
				REG_SPEED:     speed_q <= cfg_data[31:0];
				REG_COLOUR:    colour_q <= cfg_data;
				REG_SIZE:      size_q <= cfg_data[31:0];
				REG_PLACE:     place0_q <= cfg_data[47:0];
				REG_VEL:       vel0_q <= cfg_data[47:0];
				REG_ACCEL:     accel_q <= cfg_data[47:0];
				REG_COUNT:     count_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// per-slot valid bits: an unwritten slot reads as dead, at rest at the origin
	logic [63:0] dt_prod, acc_prod;
	logic [32:0] acc_sum;
	logic [32:0] age_sum;
	logic [31:0] age_new;
	logic        reborn;

	assign dt_prod  = 64'(tick_q) * 64'(speed_q);
	assign acc_prod = 64'(rate_life_q[63:32]) * 64'(dt_q);
	assign acc_sum  = 33'(accum_q) + ((acc_prod >> 16) > 64'hffffffff ?
		33'h0ffffffff : 33'(acc_prod[47:16]));
	assign age_sum  = 33'(born_q[cmd.slot] ? ages_q[cmd.slot] : 32'hffffffff) + 33'(dt_q);
	assign age_new  = age_sum[32] ? 32'hffffffff : age_sum[31:0];
	assign reborn   = age_new >= life && budget_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			born_q  <= '0;
			accum_q <= '0;
		end else begin
			if (cmd.calc_acc) accum_q <= {16'h0000, acc_sum[32] ? 16'hffff : acc_sum[15:0]};
			if (cmd.calc_pos) born_q[cmd.slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_tick) tick_q <= tick_delta;
		if (cmd.calc_dt) dt_q <= (dt_prod[63:48] != '0) ? 32'hffffffff : dt_prod[47:16];
		if (cmd.calc_acc) budget_q <= acc_sum[32] ? 32'h0000ffff : {16'h0000, acc_sum[31:16]};
		if (cmd.read_slot) begin
			for (int k = 0; k < 3; k++) begin
				p_q[k] <= born_q[cmd.slot] ? pos_q[cmd.slot][k] : '0;
				v_q[k] <= born_q[cmd.slot] ? vel_q[cmd.slot][k] : '0;
			end
		end
		if (cmd.calc_age) begin
			if (reborn) begin
				budget_q <= budget_q - 1'b1;
				age_q <= '0;
				for (int k = 0; k < 3; k++) begin
					p_q[k] <= half_q16(place0_q, 2'(k));
					v_q[k] <= half_q16(vel0_q, 2'(k));
				end
			end else begin
				age_q <= age_new;
			end
		end
		if (cmd.calc_vel)
			for (int k = 0; k < 3; k++)
				v_q[k] <= sat32(64'(v_q[k]) + mulq(half_q16(accel_q, 2'(k)), dt_q));
		if (cmd.calc_pos) begin
			ages_q[cmd.slot] <= age_q;
			for (int k = 0; k < 3; k++) begin
				p_q[k] <= sat32(64'(p_q[k]) + mulq(v_q[k], dt_q));
				pos_q[cmd.slot][k] <= sat32(64'(p_q[k]) + mulq(v_q[k], dt_q));
				vel_q[cmd.slot][k] <= v_q[k];
			end
		end
		if (cmd.div_start) ratio_q <= 17'h10000;
		if (div_done && !stat.div_skip && !cmd.div_start) ratio_q <= quot;
		if (cmd.calc_lerp) begin
			for (int l = 0; l < 4; l++)
				tint_q[8*l +: 8] <= 8'(lerp16(16'(colour_q[32+8*l +: 8]),
					16'(colour_q[8*l +: 8]), ratio_q));
			ext_q <= lerp16(size_q[31:16], size_q[15:0], ratio_q);
		end
		if (cmd.load_out) begin
			slot       <= 6'(cmd.slot);
			place_x    <= p_q[0];
			place_y    <= p_q[1];
			place_z    <= p_q[2];
			tint       <= tint_q;
			extent     <= ext_q;
			age_now    <= age_q;
			final_slot <= cmd.last;
		end
	end

	ppu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start && !(life == '0 || age_q >= life)),
		.age    (age_q),
		.life   (life),
		.done   (div_done),
		.quot   (quot)
	);

	assign stat.div_done = div_done;
	assign stat.div_skip = (life == '0) || (age_q >= life);

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for particle_pool_update
// Feeds time ticks through a valid/stall driver, walks the register set
// through several settings between phases, predicts every per-particle
// result with an independent fixed-point model of the pool and compares
// each transfer on the result channel field by field.
// ----------------------------------------------------------------------------
module tb import ppu_pkg::*; ();

	localparam int WatchLimit = 20000;
	localparam int DrainWait  = 150;

	typedef struct packed {
		logic [5:0]         slot;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic [31:0]        tint;
		logic [15:0]        ext;
		logic [31:0]        age;
		logic               last;
	} particle_rec_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [31:0]        tick_delta = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [5:0]         slot;
	logic signed [31:0] place_x, place_y, place_z;
	logic [31:0]        tint;
	logic [15:0]        extent;
	logic [31:0]        age_now;
	logic               final_slot;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [63:0]        cfg_data = '0;

	// register shadows, mirrored at every configuration write
	logic [63:0] rate_life_r;
	logic [31:0] speed_r;
	logic [63:0] colour_r;
	logic [31:0] size_r;
	logic [47:0] place_r, vel_r, accel_r;
	logic [6:0]  count_r;

	// pool state of the predictor
	logic [31:0]        age_tbl[Particles];
	logic signed [31:0] pos_tbl[Particles][3];
	logic signed [31:0] vel_tbl[Particles][3];
	logic [31:0]        spawn_frac;

	logic [31:0]   pending_ticks[$];
	particle_rec_t expected_recs[$];

	int errors = 0;
	int ticks_done = 0;
	int results_seen = 0;
	int phases_run = 0;
	int tick_gap = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	bit no_idle = 1'b0;

	particle_pool_update u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .tick_delta(tick_delta),
		.out_valid(out_valid), .out_stall(out_stall),
		.slot(slot), .place_x(place_x), .place_y(place_y), .place_z(place_z),
		.tint(tint), .extent(extent), .age_now(age_now), .final_slot(final_slot),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// --- fixed-point helpers ---------------------------------------------------

	// widen one packed Q8.8 axis (x high, z low) to Q16.16
	function automatic logic signed [31:0] axis_q16(input logic [47:0] p, input int ax);
		logic [15:0] h;
		h = p[47 - 16 * ax -: 16];
		return {{8{h[15]}}, h, 8'h00};
	endfunction

	// floor of a * dt / 2^16 with a signed and dt unsigned
	function automatic logic signed [65:0] scale_dt(input logic signed [31:0] a,
		input logic [31:0] dt);
		logic signed [65:0] p;
		p = $signed({{34{a[31]}}, a}) * $signed({34'd0, dt});
		return p >>> 16;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// floor interpolation from s toward e by ratio r/2^16
	function automatic logic [31:0] blend(input logic [31:0] s, input logic [31:0] e,
		input logic [31:0] r);
		logic [63:0] p;
		if (e >= s) begin
			p = 64'(e - s) * 64'(r);
			return s + p[47:16];
		end
		p = 64'(s - e) * 64'(r) + 64'd65535;
		return s - p[47:16];
	endfunction

	// --- predictor: advance the pool by one tick and queue its results ---------

	function automatic void advance_pool(input logic [31:0] td);
		logic [63:0]        prod;
		logic [63:0]        accsum;
		logic [31:0]        dt, life, budget, age, ratio, lane_v, size_v;
		logic [32:0]        agesum;
		logic [47:0]        quot;
		logic signed [65:0] wide;
		particle_rec_t      rec;
		int                 n;
		prod = (64'(td) * 64'(speed_r)) >> 16;
		dt = (prod > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : prod[31:0];
		life = rate_life_r[31:0];
		accsum = 64'(spawn_frac) + ((64'(rate_life_r[63:32]) * 64'(dt)) >> 16);
		if (accsum > 64'h0000_0000_ffff_ffff) accsum = 64'h0000_0000_ffff_ffff;
		budget = {16'd0, accsum[31:16]};
		spawn_frac = {16'd0, accsum[15:0]};
		n = (count_r > Particles) ? Particles : int'(count_r);
		for (int i = 0; i < n; i++) begin
			agesum = 33'(age_tbl[i]) + 33'(dt);
			age = agesum[32] ? 32'hffff_ffff : agesum[31:0];
			// rebirth only while this tick's budget lasts
			if (age >= life && budget > 0) begin
				budget--;
				age = '0;
				for (int k = 0; k < 3; k++) begin
					pos_tbl[i][k] = axis_q16(place_r, k);
					vel_tbl[i][k] = axis_q16(vel_r, k);
				end
			end
			age_tbl[i] = age;
			for (int k = 0; k < 3; k++) begin
				wide = $signed(vel_tbl[i][k]) + scale_dt(axis_q16(accel_r, k), dt);
				vel_tbl[i][k] = clamp32(wide);
				wide = $signed(pos_tbl[i][k]) + scale_dt(vel_tbl[i][k], dt);
				pos_tbl[i][k] = clamp32(wide);
			end
			if (life == 0 || age >= life) begin
				ratio = 32'd65536;
			end else begin
				quot = {age, 16'd0} / 48'(life);
				ratio = quot[31:0];
			end
			for (int l = 0; l < 4; l++) begin
				lane_v = blend(32'(colour_r[32 + 8 * l +: 8]), 32'(colour_r[8 * l +: 8]), ratio);
				rec.tint[8 * l +: 8] = lane_v[7:0];
			end
			size_v = blend(32'(size_r[31:16]), 32'(size_r[15:0]), ratio);
			rec.slot = 6'(i);
			rec.px = pos_tbl[i][0];
			rec.py = pos_tbl[i][1];
			rec.pz = pos_tbl[i][2];
			rec.ext = size_v[15:0];
			rec.age = age;
			rec.last = (i + 1 == n);
			expected_recs.push_back(rec);
		end
	endfunction

	// --- random shapes ---------------------------------------------------------

	// mostly back to back or short gaps, now and then a long one
	function automatic int pick_pause();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] pick_tick();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(0, 32'h30000);
		if (r < 92) return $urandom();
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [6:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 72) return 7'($urandom_range(1, 6));
		if (r < 78) return 7'd0;
		if (r < 84) return 7'd32;
		if (r < 88) return 7'd64;
		if (r < 91) return 7'd127;
		return 7'($urandom_range(7, 31));
	endfunction

	// --- reporting -------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// --- tick driver -------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tick_gap <= 0;
		end else begin
			// predict at the transfer, with the payload still on the port
			if (in_valid && !in_stall) begin
				advance_pool(tick_delta);
				ticks_done++;
			end
			// hold a stalled tick; otherwise advance to a gap or the next tick
			if (!in_valid || !in_stall) begin
				if (tick_gap > 0) begin
					tick_gap <= tick_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_ticks.size() > 0) begin
					in_valid <= 1'b1;
					tick_delta <= pending_ticks.pop_front();
					tick_gap <= pick_pause();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// --- result monitor and back-pressure ----------------------------------------

	always @(posedge clk or negedge arst_n) begin
		particle_rec_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_recs.size() == 0) begin
					report_mismatch("unexpected result, slot", 64'(slot), 64'd0);
				end else begin
					want = expected_recs.pop_front();
					if (slot != want.slot)
						report_mismatch("slot", 64'(slot), 64'(want.slot));
					if (place_x != want.px)
						report_mismatch("place_x", 64'(place_x), 64'(want.px));
					if (place_y != want.py)
						report_mismatch("place_y", 64'(place_y), 64'(want.py));
					if (place_z != want.pz)
						report_mismatch("place_z", 64'(place_z), 64'(want.pz));
					if (tint != want.tint)
						report_mismatch("tint", 64'(tint), 64'(want.tint));
					if (extent != want.ext)
						report_mismatch("extent", 64'(extent), 64'(want.ext));
					if (age_now != want.age)
						report_mismatch("age_now", 64'(age_now), 64'(want.age));
					if (final_slot != want.last)
						report_mismatch("final_slot", 64'(final_slot), 64'(want.last));
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				stall_left <= pick_pause();
				out_stall <= 1'b0;
			end
		end
	end

	// --- watchdog: end the run when nothing transfers for too long --------------

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("Timeout after %0d quiet cycles", quiet_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// --- configuration and phase control -----------------------------------------

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RATE_LIFE: rate_life_r = data;
			REG_SPEED:     speed_r = data[31:0];
			REG_COLOUR:    colour_r = data;
			REG_SIZE:      size_r = data[31:0];
			REG_PLACE:     place_r = data[47:0];
			REG_VEL:       vel_r = data[47:0];
			REG_ACCEL:     accel_r = data[47:0];
			REG_COUNT:     count_r = data[6:0];
			default: ;
		endcase
	endtask

	// wait until every tick is taken and every result is back, then let a
	// tick with no active particles finish its setup before the next write
	task automatic drain();
		do @(negedge clk);
		while (pending_ticks.size() > 0 || in_valid || expected_recs.size() > 0);
		repeat (DrainWait) @(negedge clk);
		phases_run++;
	endtask

	function automatic logic [47:0] pick_triple();
		if ($urandom_range(0, 2) == 0) return 48'({$urandom(), $urandom()});
		return {16'($signed($urandom_range(0, 1023)) - 512),
			16'($signed($urandom_range(0, 1023)) - 512),
			16'($signed($urandom_range(0, 1023)) - 512)};
	endfunction

	task automatic random_setup();
		logic [31:0] rate, life;
		rate = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 32'h80000);
		life = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(32'h4000, 32'h40000);
		write_reg(REG_RATE_LIFE, {rate, life});
		write_reg(REG_SPEED, 64'(($urandom_range(0, 7) == 0) ? $urandom()
			: $urandom_range(32'h8000, 32'h20000)));
		write_reg(REG_COLOUR, {$urandom(), $urandom()});
		write_reg(REG_SIZE, 64'($urandom()));
		write_reg(REG_PLACE, 64'(pick_triple()));
		write_reg(REG_VEL, 64'(pick_triple()));
		write_reg(REG_ACCEL, 64'(pick_triple()));
		write_reg(REG_COUNT, 64'(pick_count()));
	endtask

	initial begin
		rate_life_r = 64'd4295032832;
		speed_r = 32'd65536;
		colour_r = 64'hffff_ffff_0000_0000;
		size_r = 32'h0100_0100;
		place_r = '0;
		vel_r = '0;
		accel_r = '0;
		count_r = 7'd32;
		spawn_frac = '0;
		for (int i = 0; i < Particles; i++) begin
			age_tbl[i] = 32'hffff_ffff;
			for (int k = 0; k < 3; k++) begin
				pos_tbl[i][k] = '0;
				vel_tbl[i][k] = '0;
			end
		end

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: dead pool, zero, mid and saturating ticks
		pending_ticks = '{32'd0, 32'h8000, 32'hffff_ffff};
		drain();

		// steady spawning with extreme vectors and mixed colour lanes
		write_reg(REG_RATE_LIFE, {32'h0008_0000, 32'h0001_0000});
		write_reg(REG_SPEED, 64'h0000_0000_0001_0000);
		write_reg(REG_COLOUR, 64'h00ff_7f80_ff00_807f);
		write_reg(REG_SIZE, 64'h0000_0000_ffff_0000);
		write_reg(REG_PLACE, 64'h0000_7fff_8000_0001);
		write_reg(REG_VEL, 64'h0000_8000_7fff_ffff);
		write_reg(REG_ACCEL, 64'h0000_7fff_8000_0100);
		write_reg(REG_COUNT, 64'd8);
		pending_ticks = '{32'h4000, 32'h4000, 32'h4000, 32'h4000, 32'h10000, 32'h2_0000};
		drain();

		// zero lifetime, saturating accumulator and tick scale, count above pool
		write_reg(REG_RATE_LIFE, {32'hffff_ffff, 32'd0});
		write_reg(REG_SPEED, 64'h0000_0000_ffff_ffff);
		write_reg(REG_COUNT, 64'd127);
		pending_ticks = '{32'hffff_ffff, 32'd1, 32'd0};
		drain();

		// no active particles, then a single one with a tiny rate
		write_reg(REG_COUNT, 64'd0);
		write_reg(REG_SPEED, 64'h0000_0000_0001_0000);
		write_reg(REG_RATE_LIFE, {32'h0000_0001, 32'hffff_ffff});
		pending_ticks = '{32'h1_0000, 32'h5555_5555};
		drain();
		write_reg(REG_COUNT, 64'd1);
		pending_ticks = '{32'haaaa_aaaa, 32'h0001_0000};
		drain();

		// random phases: new settings, then a short run of ticks
		while (ticks_done < 150) begin
			no_idle = ($urandom_range(0, 3) == 0);
			random_setup();
			repeat ($urandom_range(6, 12)) pending_ticks.push_back(pick_tick());
			drain();
		end

		$display("Ran %0d ticks over %0d register settings, %0d particle results checked",
			ticks_done, phases_run, results_seen);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
